>>> sv/vector_norm_unit_assert.svh
`ifndef VECTOR_NORM_UNIT_ASSERT_SVH
`define VECTOR_NORM_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define VNU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define VNU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/vnu_pkg.sv
package vnu_pkg;

    localparam int DATA_W           = 32;
    localparam int ACC_W            = 64;
    localparam int NORM_W           = 48;
    localparam int MODE_W           = 2;
    localparam int ELEMENT_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF  = 2;
    localparam int ROOT_W           = ACC_W / 2;
    localparam int ROOT_STEPS       = ACC_W / 2;

    localparam logic [MODE_W-1:0] MODE_L2   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_L1   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LINF = 2'd2;

    localparam logic [ACC_W-1:0] NORM_MAX48 = (64'd1 << NORM_W) - 64'd1;
    localparam logic [ACC_W-1:0] ACC_ONES   = '1;

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic             ovf;
        logic             is_l2;
    } t_job;

endpackage

>>> sv/vector_norm_unit.sv
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata[31:0] element, tlast last
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata[47:0] norm_value, tuser saturated
// cfg       in   i_cfg_we                       i_cfg_wdata norm_mode
//
// elements are taken one per cycle unless the input stalls; a vector's result
// leaves the accumulator when its last element reaches the s2 register (after s1),
// and enters a job queue; two-norm results pass through the shared square root
// sequencer (one root bit per cycle), one- and max-norm results bypass its root steps
// synchronous active-low reset clears mode, accumulator, queue and output valid
// input stalls only when a finished vector meets a full job queue
module vector_norm_unit #(
    parameter int ELEMENT_BITS = vnu_pkg::ELEMENT_BITS_DEF,
    parameter int QUEUE_DEPTH  = vnu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [vnu_pkg::MODE_W-1:0] i_cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [vnu_pkg::DATA_W-1:0] s_axis_tdata,   // [31:0] element
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [vnu_pkg::NORM_W-1:0] m_axis_tdata,   // [47:0] norm_value
    output logic                       m_axis_tuser    // [0] saturated
);
    import vnu_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_job w_in_job;
    t_job w_out_job;

    vnu_front #(
        .ELEMENT_BITS(ELEMENT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .o_push       (w_push),
        .o_job        (w_in_job),
        .i_full       (w_full)
    );

    vnu_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_in_job),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_job  (w_out_job),
        .o_empty(w_empty)
    );

    vnu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (w_out_job),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

endmodule

>>> sv/vnu_front.sv
module vnu_front #(
    parameter int ELEMENT_BITS = vnu_pkg::ELEMENT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [vnu_pkg::MODE_W-1:0] i_cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [vnu_pkg::DATA_W-1:0] s_axis_tdata,
    input  logic                       s_axis_tlast,
    output logic                       o_push,
    output vnu_pkg::t_job              o_job,
    input  logic                       i_full
);
    import vnu_pkg::*;

    localparam int EB = ELEMENT_BITS;

    logic [MODE_W-1:0] r_mode;

    logic              r_s1_v;
    logic [EB-1:0]     r_s1_mag;
    logic              r_s1_last;
    logic [MODE_W-1:0] r_s1_mode;

    logic              r_s2_v;
    logic [ACC_W-1:0]  r_s2_val;
    logic              r_s2_last;
    logic [MODE_W-1:0] r_s2_mode;

    logic [ACC_W-1:0]  r_acc;
    logic              r_ovf;
    logic [ACC_W-1:0]  n_acc;
    logic              n_ovf;

    logic [EB-1:0]     w_raw;
    logic [EB-1:0]     w_mag;
    logic [2*EB-1:0]   w_sq;
    logic [ACC_W:0]    w_sum;
    logic              w_adv;

    assign w_raw = s_axis_tdata[EB-1:0];
    assign w_mag = w_raw[EB-1] ? (~w_raw + EB'(1)) : w_raw;
    assign w_sq  = r_s1_mag * r_s1_mag;
    assign w_sum = {1'b0, r_acc} + {1'b0, r_s2_val};

    // only a finished vector facing a full queue holds the pipe
    assign w_adv         = !(r_s2_v && r_s2_last && i_full);
    assign s_axis_tready = w_adv;
    assign o_push        = r_s2_v && r_s2_last && w_adv;

    always_comb begin
        n_acc = r_acc;
        n_ovf = r_ovf;
        unique case (r_s2_mode)
            MODE_L2: begin
                if (w_sum[ACC_W]) begin
                    n_acc = ACC_ONES;
                    n_ovf = 1'b1;
                end else begin
                    n_acc = w_sum[ACC_W-1:0];
                end
            end
            MODE_L1: begin
                if (w_sum > {1'b0, NORM_MAX48}) begin
                    n_acc = NORM_MAX48;
                    n_ovf = 1'b1;
                end else begin
                    n_acc = w_sum[ACC_W-1:0];
                end
            end
            default: begin
                if (r_s2_val > r_acc) begin
                    n_acc = r_s2_val;
                end
            end
        endcase
    end

    always_comb begin
        o_job.acc   = n_acc;
        o_job.ovf   = n_ovf;
        o_job.is_l2 = (r_s2_mode == MODE_L2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_L2;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_acc  <= '0;
            r_ovf  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (w_adv) begin
                r_s1_v <= s_axis_tvalid;
                r_s2_v <= r_s1_v;
                if (r_s2_v) begin
                    if (r_s2_last) begin
                        r_acc <= '0;
                        r_ovf <= 1'b0;
                    end else begin
                        r_acc <= n_acc;
                        r_ovf <= n_ovf;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_mag  <= w_mag;
            r_s1_last <= s_axis_tlast;
            r_s1_mode <= r_mode;
            r_s2_val  <= (r_s1_mode == MODE_L2) ? ACC_W'(w_sq) : ACC_W'(r_s1_mag);
            r_s2_last <= r_s1_last;
            r_s2_mode <= r_s1_mode;
        end
    end

endmodule

>>> sv/vnu_queue.sv
`include "vector_norm_unit_assert.svh"

module vnu_queue #(
    parameter int QUEUE_DEPTH = vnu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vnu_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output vnu_pkg::t_job o_job,
    output logic          o_empty
);
    import vnu_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    `VNU_ASSERT_NOW(a_q_no_overrun, i_push, !o_full, "push into full queue")
    `VNU_ASSERT_NOW(a_q_no_underrun, i_pop, !o_empty, "pop from empty queue")
    `VNU_ASSERT_NXT(a_q_push_lands, i_push && !i_pop, !o_empty, "pushed job not visible")

endmodule

>>> sv/vnu_back.sv
`include "vector_norm_unit_assert.svh"

module vnu_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  vnu_pkg::t_job              i_job,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [vnu_pkg::NORM_W-1:0] m_axis_tdata,
    output logic                       m_axis_tuser
);
    import vnu_pkg::*;

    localparam int SW = $clog2(ROOT_STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROOT,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [ACC_W-1:0]    r_rad;
    logic [ROOT_W+1:0]   r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [SW-1:0]       r_cnt;
    logic [NORM_W-1:0]   r_res;
    logic                r_ovf;
    logic                r_out_v;
    logic [NORM_W-1:0]   r_out_data;
    logic                r_out_sat;

    logic [ROOT_W+1:0]   w_remx;
    logic [ROOT_W+1:0]   w_trial;
    logic                w_take;
    logic [ROOT_W+1:0]   n_rem;
    logic [ROOT_W-1:0]   n_root;
    logic                w_out_free;

    // one result bit per cycle, restoring square root
    assign w_remx  = {r_rem[ROOT_W-1:0], r_rad[ACC_W-1 -: 2]};
    assign w_trial = {r_root, 2'b01};
    assign w_take  = (w_remx >= w_trial);
    assign n_rem   = w_take ? (w_remx - w_trial) : w_remx;
    assign n_root  = {r_root[ROOT_W-2:0], w_take};

    assign w_out_free    = !r_out_v || m_axis_tready;
    assign o_pop         = (r_state == S_IDLE) && !i_empty;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
        end else begin
            if (m_axis_tready && r_state != S_FIN) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_ovf <= i_job.ovf;
                        if (i_job.is_l2) begin
                            r_rad   <= i_job.acc;
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_cnt   <= '0;
                            r_state <= S_ROOT;
                        end else begin
                            r_res   <= (i_job.acc > NORM_MAX48) ? NORM_MAX48[NORM_W-1:0]
                                                                : i_job.acc[NORM_W-1:0];
                            r_state <= S_FIN;
                        end
                    end
                end
                S_ROOT: begin
                    r_rad  <= {r_rad[ACC_W-3:0], 2'b00};
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_cnt  <= r_cnt + SW'(1);
                    if (r_cnt == SW'(ROOT_STEPS - 1)) begin
                        r_res   <= NORM_W'(n_root);
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_v    <= 1'b1;
                        r_out_data <= r_res;
                        r_out_sat  <= r_ovf;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `VNU_ASSERT_NOW(a_b_pop_idle, o_pop, r_state == S_IDLE, "queue popped while busy")
    `VNU_ASSERT_NOW(a_b_rise_fin, $rose(r_out_v), $past(r_state) == S_FIN,
                    "result shown without finish step")
    `VNU_ASSERT_NXT(a_b_root_span, r_state == S_ROOT && r_cnt != SW'(ROOT_STEPS - 1),
                    r_state == S_ROOT, "square root left early")

endmodule
